>>> rtl/core/wsfr_pkg.sv
// Shared types and constants for the WebSocket frame receiver.
package wsfr_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam logic [15:0] CAPACITY_RESET = 16'd4096;

  typedef enum logic [2:0] {
    KIND_DATA  = 3'd0,
    KIND_CTRL  = 3'd1,
    KIND_DONE  = 3'd2,
    KIND_PONG  = 3'd3,
    KIND_CLOSE = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    WHY_NORMAL = 2'd0,
    WHY_PROTO  = 2'd1,
    WHY_BIG    = 2'd2
  } why_t;

  typedef enum logic [2:0] {
    PH_HEAD0   = 3'd0,
    PH_HEAD1   = 3'd1,
    PH_EXT     = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic        is_text;
    logic [15:0] message_length;
    why_t        close_reason;
    logic        last;
  } result_t;

endpackage

>>> rtl/core/wsfr_if.sv
// Handshake channels of the WebSocket frame receiver.
interface wsfr_rx_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;
  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

interface wsfr_ev_if;
  logic                valid;
  logic                ready;
  wsfr_pkg::kind_t     kind;
  logic [7:0]          payload_byte;
  logic                is_text;
  logic [15:0]         message_length;
  wsfr_pkg::why_t      close_reason;
  logic                last;
  modport source (output valid, output kind, output payload_byte, output is_text,
                  output message_length, output close_reason, output last,
                  input ready);
  modport sink (input valid, input kind, input payload_byte, input is_text,
                input message_length, input close_reason, input last,
                output ready);
endinterface

interface wsfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/websocket_frame_receiver_top.sv
// Top level of the WebSocket frame receiver (client-to-server deframer).
//
// rx carries one request per received byte (operation 0) or a new-connection
// marker (operation 1), which clears frame and message state and reopens.
// ev carries zero, one or two results per request: data byte, control byte, message
// complete, pong requested or close requested, with last on the final result
// of each input byte. cfg writes message_capacity (reset 4096); write only
// while the block is idle.
// Each byte is handled in the cycle it is accepted by the parser; its results
// are written into a small result queue whose head drives ev. One byte can be
// taken every cycle while each byte makes at most one result and ev is not
// stalled; a byte making two results shows them on ev one after the other.
// rx.ready drops when the queue lacks room for two results, so a stalled sink
// backs up rx and no result is lost. Reset empties the queue, restores the
// capacity and clears all parser state except the mask key.
module websocket_frame_receiver_top #(
  parameter int unsigned FIFO_DEPTH = wsfr_pkg::FIFO_DEPTH
) (
  input logic      clk,
  input logic      rst,
  wsfr_rx_if.sink  rx,
  wsfr_ev_if.source ev,
  wsfr_cfg_if.sink cfg
);

  logic [15:0]       capacity;
  logic              accept;
  logic              room_for_two;
  logic              not_empty;
  logic [1:0]        res_count;
  wsfr_pkg::result_t res0, res1, head;

  assign cfg.ready = 1'b1;
  assign rx.ready  = room_for_two;
  assign accept    = rx.valid && room_for_two;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= wsfr_pkg::CAPACITY_RESET;
    end else if (cfg.valid) begin
      capacity <= cfg.data;
    end
  end

  wsfr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (rx.operation),
    .rx_byte   (rx.rx_byte),
    .capacity  (capacity),
    .res0      (res0),
    .res1      (res1),
    .res_count (res_count)
  );

  wsfr_result_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk          (clk),
    .rst          (rst),
    .push_count   (res_count),
    .push0        (res0),
    .push1        (res1),
    .pop          (ev.ready),
    .head         (head),
    .not_empty    (not_empty),
    .room_for_two (room_for_two)
  );

  assign ev.valid          = not_empty;
  assign ev.kind           = head.kind;
  assign ev.payload_byte   = head.payload_byte;
  assign ev.is_text        = head.is_text;
  assign ev.message_length = head.message_length;
  assign ev.close_reason   = head.close_reason;
  assign ev.last           = head.last;

endmodule

>>> rtl/core/wsfr_result_fifo.sv
// Small result queue: up to two pushes and one pop per cycle.
module wsfr_result_fifo #(
  parameter int unsigned DEPTH = wsfr_pkg::FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_count,
  input  wsfr_pkg::result_t push0,
  input  wsfr_pkg::result_t push1,
  input  logic              pop,
  output wsfr_pkg::result_t head,
  output logic              not_empty,
  output logic              room_for_two
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  wsfr_pkg::result_t mem [DEPTH];
  logic [PTR_W-1:0] wptr, rptr, wptr_plus1;
  logic [CNT_W-1:0] count, count_next;
  logic             do_pop;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign wptr_plus1   = wrap_inc(wptr);
  assign head         = mem[rptr];
  assign not_empty    = (count != '0);
  assign room_for_two = (count <= CNT_W'(DEPTH - 2));
  assign do_pop       = pop && not_empty;
  assign count_next   = count + CNT_W'(push_count) - CNT_W'(do_pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (do_pop) begin
        rptr <= wrap_inc(rptr);
      end
      case (push_count)
        2'd1:    wptr <= wptr_plus1;
        2'd2:    wptr <= wrap_inc(wptr_plus1);
        default: wptr <= wptr;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wptr] <= push0;
    end
    if (push_count == 2'd2) begin
      mem[wptr_plus1] <= push1;
    end
  end

endmodule

>>> rtl/core/wsfr_parser.sv
// Frame parser: header, length, mask key, unmasking and event generation.
module wsfr_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              operation,
  input  logic [7:0]        rx_byte,
  input  logic [15:0]       capacity,
  output wsfr_pkg::result_t res0,
  output wsfr_pkg::result_t res1,
  output logic [1:0]        res_count
);

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [1:0] MSG_NONE  = 2'd0;
  localparam logic [1:0] MSG_TEXT  = 2'd1;

  wsfr_pkg::phase_t phase, phase_next;
  logic [3:0]  frame_opcode, frame_opcode_next;
  logic        frame_final, frame_final_next;
  logic        frame_is_control, frame_is_control_next;
  logic [1:0]  ext_len_left, ext_len_left_next;
  logic [7:0]  mask_key [4];
  logic [1:0]  mask_index, mask_index_next;
  logic [15:0] payload_index, payload_index_next;
  logic [15:0] payload_total, payload_total_next;
  logic [1:0]  message_type, message_type_next;
  logic [15:0] message_count, message_count_next;
  logic        closed, closed_next;

  logic              key_we;
  logic              emit_byte;
  wsfr_pkg::kind_t   byte_kind;
  logic [7:0]        plain;
  logic              fend;
  logic              close_now;
  wsfr_pkg::why_t    close_why;
  logic              evt_valid;
  wsfr_pkg::result_t evt, byte_res;
  logic              clr;
  logic              new_conn;

  always_comb begin
    phase_next            = phase;
    frame_opcode_next     = frame_opcode;
    frame_final_next      = frame_final;
    frame_is_control_next = frame_is_control;
    ext_len_left_next     = ext_len_left;
    mask_index_next       = mask_index;
    payload_index_next    = payload_index;
    payload_total_next    = payload_total;
    message_type_next     = message_type;
    message_count_next    = message_count;
    closed_next           = closed;
    key_we    = 1'b0;
    emit_byte = 1'b0;
    byte_kind = wsfr_pkg::KIND_DATA;
    plain     = rx_byte ^ mask_key[payload_index[1:0]];
    fend      = 1'b0;
    close_now = 1'b0;
    close_why = wsfr_pkg::WHY_NORMAL;
    evt_valid = 1'b0;
    evt       = '0;
    clr       = 1'b0;
    new_conn  = accept && operation;

    if (accept && !operation && !closed) begin
      unique case (phase)
        wsfr_pkg::PH_HEAD0: begin
          frame_final_next      = rx_byte[7];
          frame_opcode_next     = rx_byte[3:0];
          frame_is_control_next = rx_byte[3];
          phase_next            = wsfr_pkg::PH_HEAD1;
          if (rx_byte[3]) begin
            if (!rx_byte[7]) begin
              close_now = 1'b1;
              close_why = wsfr_pkg::WHY_PROTO;
            end
          end else begin
            case (rx_byte[3:0]) inside
              OP_CONT: begin
                if (message_type == MSG_NONE) begin
                  close_now = 1'b1;
                  close_why = wsfr_pkg::WHY_PROTO;
                end
              end
              OP_TEXT, OP_BINARY: begin
                if (message_type != MSG_NONE) begin
                  close_now = 1'b1;
                  close_why = wsfr_pkg::WHY_PROTO;
                end else begin
                  message_type_next  = rx_byte[1:0];
                  message_count_next = '0;
                end
              end
              default: begin
                close_now = 1'b1;
                close_why = wsfr_pkg::WHY_PROTO;
              end
            endcase
          end
        end
        wsfr_pkg::PH_HEAD1: begin
          if (!rx_byte[7]) begin
            close_now = 1'b1;
            close_why = wsfr_pkg::WHY_PROTO;
          end else if (frame_is_control && rx_byte[6:0] >= LEN_EXT16) begin
            close_now = 1'b1;
            close_why = wsfr_pkg::WHY_PROTO;
          end else if (rx_byte[6:0] == LEN_EXT64) begin
            close_now = 1'b1;
            close_why = wsfr_pkg::WHY_BIG;
          end else if (rx_byte[6:0] == LEN_EXT16) begin
            payload_total_next = '0;
            ext_len_left_next  = 2'd2;
            phase_next         = wsfr_pkg::PH_EXT;
          end else begin
            payload_total_next = {9'd0, rx_byte[6:0]};
            ext_len_left_next  = 2'd0;
            phase_next         = wsfr_pkg::PH_MASK;
          end
        end
        wsfr_pkg::PH_EXT: begin
          payload_total_next = {payload_total[7:0], rx_byte};
          ext_len_left_next  = ext_len_left - 2'd1;
          if (ext_len_left_next == 2'd0) begin
            if (!frame_is_control &&
                ({1'b0, message_count} + {1'b0, payload_total_next} >
                 {1'b0, capacity})) begin
              close_now = 1'b1;
              close_why = wsfr_pkg::WHY_BIG;
            end else begin
              phase_next = wsfr_pkg::PH_MASK;
            end
          end
        end
        wsfr_pkg::PH_MASK: begin
          key_we          = 1'b1;
          mask_index_next = mask_index + 2'd1;
          if (mask_index_next == 2'd0) begin
            if (payload_total == '0) begin
              fend = 1'b1;
            end else begin
              phase_next = wsfr_pkg::PH_PAYLOAD;
            end
          end
        end
        wsfr_pkg::PH_PAYLOAD: begin
          if (frame_is_control) begin
            emit_byte = 1'b1;
            byte_kind = wsfr_pkg::KIND_CTRL;
          end else if (message_count < capacity) begin
            emit_byte          = 1'b1;
            message_count_next = message_count + 16'd1;
          end
          payload_index_next = payload_index + 16'd1;
          if (payload_index_next >= payload_total) begin
            fend = 1'b1;
          end
        end
        default: begin
          clr = 1'b1;
        end
      endcase

      if (fend) begin
        clr = 1'b1;
        if (frame_is_control) begin
          case (frame_opcode)
            OP_CLOSE: begin
              close_now = 1'b1;
              close_why = wsfr_pkg::WHY_NORMAL;
            end
            OP_PING: begin
              evt_valid = 1'b1;
              evt.kind  = wsfr_pkg::KIND_PONG;
            end
            OP_PONG: ;
            default: begin
              close_now = 1'b1;
              close_why = wsfr_pkg::WHY_PROTO;
            end
          endcase
        end else if (frame_final) begin
          evt_valid          = 1'b1;
          evt.kind           = wsfr_pkg::KIND_DONE;
          evt.is_text        = (message_type == MSG_TEXT);
          evt.message_length = message_count_next;
          message_type_next  = MSG_NONE;
          message_count_next = '0;
        end
      end

      if (close_now) begin
        clr              = 1'b1;
        closed_next      = 1'b1;
        evt_valid        = 1'b1;
        evt              = '0;
        evt.kind         = wsfr_pkg::KIND_CLOSE;
        evt.close_reason = close_why;
      end
    end

    if (clr || new_conn) begin
      phase_next            = wsfr_pkg::PH_HEAD0;
      frame_opcode_next     = '0;
      frame_final_next      = 1'b0;
      frame_is_control_next = 1'b0;
      ext_len_left_next     = '0;
      mask_index_next       = '0;
      payload_index_next    = '0;
      payload_total_next    = '0;
    end
    if (new_conn) begin
      message_type_next  = MSG_NONE;
      message_count_next = '0;
      closed_next        = 1'b0;
    end

    byte_res              = '0;
    byte_res.kind         = byte_kind;
    byte_res.payload_byte = plain;
    byte_res.last         = !evt_valid;
    evt.last              = 1'b1;

    res_count = {1'b0, emit_byte} + {1'b0, evt_valid};
    res0      = emit_byte ? byte_res : evt;
    res1      = evt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= wsfr_pkg::PH_HEAD0;
      frame_opcode     <= '0;
      frame_final      <= 1'b0;
      frame_is_control <= 1'b0;
      ext_len_left     <= '0;
      mask_index       <= '0;
      payload_index    <= '0;
      payload_total    <= '0;
      message_type     <= MSG_NONE;
      message_count    <= '0;
      closed           <= 1'b0;
    end else begin
      phase            <= phase_next;
      frame_opcode     <= frame_opcode_next;
      frame_final      <= frame_final_next;
      frame_is_control <= frame_is_control_next;
      ext_len_left     <= ext_len_left_next;
      mask_index       <= mask_index_next;
      payload_index    <= payload_index_next;
      payload_total    <= payload_total_next;
      message_type     <= message_type_next;
      message_count    <= message_count_next;
      closed           <= closed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      mask_key[mask_index] <= rx_byte;
    end
  end

endmodule
